[rtl/core/angle_to_sexagesimal_ascii_core_macros.svh]
// Assertion macros shared by the angle formatter core.
`ifndef ANGLE_TO_SEXAGESIMAL_ASCII_CORE_MACROS_SVH
`define ANGLE_TO_SEXAGESIMAL_ASCII_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold on every clock edge out of reset.
`define AS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be seen on a clock edge out of reset.
`define AS_NEVER(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) not (prop)) else $error(msg);
`else
`define AS_CHECK(lbl, prop, msg)
`define AS_NEVER(lbl, prop, msg)
`endif
`endif

[rtl/core/angsex_pkg.sv]
// Types, constants and helpers for the sexagesimal angle formatter.
`timescale 1ns / 1ps
package angsex_pkg;

	// Input angle format.
	localparam int ANGLE_W   = 48;
	localparam int FRAC_BITS = 40;
	// The magnitude is split in two halves for the scaling multiply.
	localparam int SPLIT     = 24;
	localparam int HI_W      = ANGLE_W - SPLIT;
	localparam int K_W       = 38;
	localparam int PP_W      = HI_W + K_W;
	localparam int SUM_W     = PP_W + 1;
	// Scaled value: whole units and 32 fraction bits.
	localparam int UFRAC_W   = 32;
	localparam int WHOLE_W   = 13;
	localparam int D_W       = WHOLE_W + UFRAC_W;

	// Degrees and hours per radian, 32 fraction bits, rounded to nearest.
	localparam logic [63:0] SCALE_DEG64 = (64'd57 << 32) +
		(((64'd29577951 << 32) + 64'd50000000) / 64'd100000000);
	localparam logic [63:0] SCALE_HRS64 = (64'd3 << 32) +
		(((64'd1229577951 << 32) + 64'd750000000) / 64'd1500000000);
	localparam logic [K_W-1:0] SCALE_DEG = SCALE_DEG64[K_W-1:0];
	localparam logic [K_W-1:0] SCALE_HRS = SCALE_HRS64[K_W-1:0];
	// Rounding offset of 0.000014 unit.
	localparam logic [63:0] ROUND_OFS64 = ((64'd14 << 32) + 64'd500000) / 64'd1000000;
	localparam logic [D_W-1:0] ROUND_OFS = ROUND_OFS64[D_W-1:0];

	// Mode codes.
	localparam logic CMD_HOURS = 1'b0;
	localparam logic CMD_DEG   = 1'b1;

	// Field limits and text lengths.
	localparam logic [WHOLE_W-1:0] HRS_MAX = 13'd99;
	localparam logic [WHOLE_W-1:0] DEG_MAX = 13'd999;
	localparam logic [3:0] LEN_HOURS = 4'd10;
	localparam logic [3:0] LEN_DEG   = 4'd12;

	// Reciprocal multipliers for small divisions.
	localparam logic [7:0] RECIP10  = 8'd205;
	localparam logic [5:0] RECIP100 = 6'd41;

	// ASCII characters.
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Scaled angle handed from the scaler to the splitter.
	typedef struct packed {
		logic               cmd;
		logic               neg;
		logic [WHOLE_W-1:0] whole;
		logic [UFRAC_W-1:0] frac;
	} scl_t;

	// Split fields handed from the splitter to the formatter.
	typedef struct packed {
		logic               cmd;
		logic               neg;
		logic               ovf;
		logic [3:0]         hund;
		logic [6:0]         rem;
		logic [3:0]         min_t;
		logic [3:0]         min_o;
		logic [5:0]         secs;
		logic [UFRAC_W-1:0] frac_s;
	} spl_t;

	// ASCII code of one decimal digit.
	function automatic logic [7:0] ascii_digit(input logic [3:0] d);
		ascii_digit = {4'h3, d};
	endfunction

endpackage

[rtl/core/angsex_scale.sv]
// Magnitude, scaling multiply and rounding offset: three pipeline stages.
`timescale 1ns / 1ps
module angsex_scale
	import angsex_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               cmd,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic               valid_s3,
	output scl_t               scl_s3
);

	logic               valid_s1, valid_s2;
	logic               cmd_s1, cmd_s2, neg_s1, neg_s2;
	logic [ANGLE_W-1:0] mag_s1;
	logic [PP_W-1:0]    pp_hi_s2, pp_lo_s2;
	logic [ANGLE_W-1:0] ang_u;
	logic [K_W-1:0]     k;
	logic [SUM_W-1:0]   pp_sum;
	logic [SUM_W-1:0]   pp_shift;
	logic [D_W-1:0]     d;

	// Valid bits advance with the shared enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: sign and magnitude of the angle.
	assign ang_u = angle;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;
			neg_s1 <= ang_u[ANGLE_W-1];
			mag_s1 <= ang_u[ANGLE_W-1] ? (~ang_u + 1'b1) : ang_u;
		end
	end

	// Stage 2: two partial products of magnitude times scale.
	assign k = (cmd_s1 == CMD_DEG) ? SCALE_DEG : SCALE_HRS;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= cmd_s1;
			neg_s2   <= neg_s1;
			pp_hi_s2 <= {{K_W{1'b0}}, mag_s1[ANGLE_W-1:SPLIT]} * {{HI_W{1'b0}}, k};
			pp_lo_s2 <= {{(PP_W-SPLIT){1'b0}}, mag_s1[SPLIT-1:0]} *
				{{(PP_W-K_W){1'b0}}, k};
		end
	end

	// Stage 3: combine partial products, drop fraction bits, add rounding offset.
	assign pp_sum   = {1'b0, pp_hi_s2} + {1'b0, (pp_lo_s2 >> SPLIT)};
	assign pp_shift = pp_sum >> (FRAC_BITS - SPLIT);
	assign d        = pp_shift[D_W-1:0] + ROUND_OFS;

	always_ff @(posedge clk) begin
		if (en) begin
			scl_s3.cmd   <= cmd_s2;
			scl_s3.neg   <= neg_s2;
			scl_s3.whole <= d[D_W-1:UFRAC_W];
			scl_s3.frac  <= d[UFRAC_W-1:0];
		end
	end

endmodule

[rtl/core/angsex_split.sv]
// Minutes, seconds and unit digits: two pipeline stages.
`timescale 1ns / 1ps
`include "angle_to_sexagesimal_ascii_core_macros.svh"
module angsex_split
	import angsex_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s3,
	input  scl_t scl_s3,
	output logic valid_s5,
	output spl_t spl_s5
);

	logic               valid_s4;
	logic               cmd_s4, neg_s4, ovf_s4;
	logic [5:0]         mins_s4;
	logic [UFRAC_W-1:0] fracm_s4;
	logic [9:0]         w10_s4;
	logic [3:0]         hund_s4;
	logic [UFRAC_W+5:0] m_prod, s_prod;
	logic [15:0]        h_prod;
	logic               ovf;
	logic [9:0]         h_x100;
	logic [9:0]         rem10;
	logic [13:0]        mt_prod;
	logic [2:0]         min_t;
	logic [5:0]         min_t10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 4: minutes from the unit fraction, field overflow, hundreds digit.
	assign m_prod = {6'd0, scl_s3.frac} * 38'd60;
	assign h_prod = {6'd0, scl_s3.whole[9:0]} * {10'd0, RECIP100};

	always_comb begin
		if (scl_s3.cmd == CMD_DEG) begin
			ovf = scl_s3.whole > DEG_MAX;
		end else begin
			ovf = (scl_s3.neg && (scl_s3.whole != '0)) || (scl_s3.whole > HRS_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4   <= scl_s3.cmd;
			neg_s4   <= scl_s3.neg;
			ovf_s4   <= ovf;
			mins_s4  <= m_prod[UFRAC_W+5:UFRAC_W];
			fracm_s4 <= m_prod[UFRAC_W-1:0];
			w10_s4   <= scl_s3.whole[9:0];
			hund_s4  <= h_prod[15:12];
		end
	end

	// Stage 5: seconds, remainder below hundreds, minute digits.
	assign s_prod  = {6'd0, fracm_s4} * 38'd60;
	assign h_x100  = {6'd0, hund_s4} * 10'd100;
	assign rem10   = w10_s4 - h_x100;
	assign mt_prod = {8'd0, mins_s4} * {6'd0, RECIP10};
	assign min_t   = mt_prod[13:11];
	assign min_t10 = {3'd0, min_t} * 6'd10;

	always_ff @(posedge clk) begin
		if (en) begin
			spl_s5.cmd    <= cmd_s4;
			spl_s5.neg    <= neg_s4;
			spl_s5.ovf    <= ovf_s4;
			spl_s5.hund   <= hund_s4;
			spl_s5.rem    <= rem10[6:0];
			spl_s5.min_t  <= {1'b0, min_t};
			spl_s5.min_o  <= 4'(mins_s4 - min_t10);
			spl_s5.secs   <= s_prod[UFRAC_W+5:UFRAC_W];
			spl_s5.frac_s <= s_prod[UFRAC_W-1:0];
		end
	end

	`AS_CHECK(a_mins_range, valid_s4 |-> (mins_s4 < 6'd60), "minutes out of range")
	`AS_CHECK(a_secs_range, valid_s5 |-> (spl_s5.secs < 6'd60), "seconds out of range")
	`AS_CHECK(a_rem_range, (valid_s5 && !spl_s5.ovf) |-> (spl_s5.rem < 7'd100),
		"remainder below hundreds out of range")

endmodule

[rtl/core/angsex_format.sv]
// Tenths, remaining digits and ASCII assembly into the output register.
`timescale 1ns / 1ps
module angsex_format
	import angsex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_s5,
	input  spl_t        spl_s5,
	output logic        valid_s6,
	output logic [63:0] head_s6,
	output logic [31:0] tail_s6,
	output logic [3:0]  len_s6,
	output logic        ovf_s6
);

	logic [UFRAC_W+3:0] t_prod;
	logic [3:0]         tenth;
	logic [13:0]        st_prod;
	logic [2:0]         sec_t;
	logic [5:0]         sec_t10;
	logic [3:0]         sec_o;
	logic [14:0]        wt_prod;
	logic [3:0]         w_t;
	logic [6:0]         w_t10;
	logic [3:0]         w_o;
	logic [7:0]         c_sec_t, c_sec_o, c_tenth, c_min_t, c_min_o, c_w_t, c_w_o;
	logic [63:0]        head;
	logic [31:0]        tail;
	logic [3:0]         len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	// Tenths of a second, truncated.
	assign t_prod = {4'd0, spl_s5.frac_s} * 36'd10;
	assign tenth  = t_prod[UFRAC_W+3:UFRAC_W];

	// Seconds digits.
	assign st_prod = {8'd0, spl_s5.secs} * {6'd0, RECIP10};
	assign sec_t   = st_prod[13:11];
	assign sec_t10 = {3'd0, sec_t} * 6'd10;
	assign sec_o   = 4'(spl_s5.secs - sec_t10);

	// Tens and ones of the unit field.
	assign wt_prod = {8'd0, spl_s5.rem} * {7'd0, RECIP10};
	assign w_t     = wt_prod[14:11];
	assign w_t10   = {3'd0, w_t} * 7'd10;
	assign w_o     = 4'(spl_s5.rem - w_t10);

	assign c_sec_t = ascii_digit({1'b0, sec_t});
	assign c_sec_o = ascii_digit(sec_o);
	assign c_tenth = ascii_digit(tenth);
	assign c_min_t = ascii_digit(spl_s5.min_t);
	assign c_min_o = ascii_digit(spl_s5.min_o);
	assign c_w_t   = ascii_digit(w_t);
	assign c_w_o   = ascii_digit(w_o);

	// Character layout for the two modes.
	always_comb begin
		case (spl_s5.cmd)
			CMD_HOURS: begin
				len = LEN_HOURS;
				if (spl_s5.ovf) begin
					head[63:48] = {CH_STAR, CH_STAR};
				end else begin
					head[63:48] = {c_w_t, c_w_o};
				end
				head[47:0] = {CH_COLON, c_min_t, c_min_o, CH_COLON, c_sec_t, c_sec_o};
				tail = {CH_DOT, c_tenth, CH_NUL, CH_NUL};
			end
			CMD_DEG: begin
				len = LEN_DEG;
				if (spl_s5.ovf) begin
					head[63:32] = {CH_STAR, CH_STAR, CH_STAR, CH_STAR};
				end else begin
					head[63:32] = {(spl_s5.neg ? CH_MINUS : CH_PLUS),
						ascii_digit(spl_s5.hund), c_w_t, c_w_o};
				end
				head[31:0] = {CH_COLON, c_min_t, c_min_o, CH_COLON};
				tail = {c_sec_t, c_sec_o, CH_DOT, c_tenth};
			end
			default: begin
				len  = LEN_HOURS;
				head = '0;
				tail = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s6 <= head;
			tail_s6 <= tail;
			len_s6  <= len;
			ovf_s6  <= spl_s5.ovf;
		end
	end

endmodule

[rtl/core/angle_to_sexagesimal_ascii_core.sv]
// A word accepted with ang_valid passes the stage registers s1 to s6 in order before it appears on txt_valid.
// Throughput: one word per cycle while the output is not stalled; the six-stage pipeline advances on one shared enable.
// A stall on a valid output word holds every stage and raises ang_stall in the same cycle.
// Reset (arst_n low) clears all stage valid bits at once; payload registers are not reset.
`timescale 1ns / 1ps
`include "angle_to_sexagesimal_ascii_core_macros.svh"
module angle_to_sexagesimal_ascii_core
	import angsex_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ang_valid,
	output logic                      ang_stall,
	input  logic                      cmd,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      txt_valid,
	input  logic                      txt_stall,
	output logic [63:0]               text_head,
	output logic [31:0]               text_tail,
	output logic [3:0]                text_length,
	output logic                      field_overflow
);

	logic en;
	logic valid_s3, valid_s5;
	scl_t scl_s3;
	spl_t spl_s5;

	// The pipeline moves whenever the output register is empty or being taken.
	assign en        = !txt_valid || !txt_stall;
	assign ang_stall = !en;

	angsex_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (ang_valid),
		.cmd      (cmd),
		.angle    (angle),
		.valid_s3 (valid_s3),
		.scl_s3   (scl_s3)
	);

	angsex_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.scl_s3   (scl_s3),
		.valid_s5 (valid_s5),
		.spl_s5   (spl_s5)
	);

	angsex_format u_format (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s5 (valid_s5),
		.spl_s5   (spl_s5),
		.valid_s6 (txt_valid),
		.head_s6  (text_head),
		.tail_s6  (text_tail),
		.len_s6   (text_length),
		.ovf_s6   (field_overflow)
	);

	`AS_CHECK(a_ovf_star, (txt_valid && field_overflow) |-> (text_head[63:56] == CH_STAR),
		"overflow word without asterisks")
	`AS_CHECK(a_deg_sign, (txt_valid && !field_overflow && (text_length == LEN_DEG)) |->
		((text_head[63:56] == CH_PLUS) || (text_head[63:56] == CH_MINUS)),
		"degree word without sign")
	`AS_CHECK(a_hrs_pad, (txt_valid && (text_length == LEN_HOURS)) |->
		(text_tail[15:0] == 16'h0000), "hour word has nonzero padding")

endmodule

[bench/angle_to_sexagesimal_ascii_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the radians to sexagesimal ASCII formatter core.
module angle_to_sexagesimal_ascii_core_test;
	import angsex_pkg::*;

	// Scale factors and rounding offset, all with 32 fraction bits of a unit.
	localparam logic [63:0] DEG_PER_RAD = (64'd57 << 32) +
		(((64'd29577951 << 32) + 64'd50000000) / 64'd100000000);
	localparam logic [63:0] HRS_PER_RAD = (64'd3 << 32) +
		(((64'd1229577951 << 32) + 64'd750000000) / 64'd1500000000);
	localparam logic [63:0] ROUND_UNIT = ((64'd14 << 32) + 64'd500000) / 64'd1000000;
	// Roughly two pi in angle units.
	localparam logic [63:0] TWO_PI_UNITS = 64'd6908435316000;
	localparam int TENTHS_PER_UNIT = 36000;

	localparam logic [7:0] A_ZERO  = 8'h30;
	localparam logic [7:0] A_STAR  = 8'h2A;
	localparam logic [7:0] A_PLUS  = 8'h2B;
	localparam logic [7:0] A_MINUS = 8'h2D;
	localparam logic [7:0] A_DOT   = 8'h2E;
	localparam logic [7:0] A_COLON = 8'h3A;

	typedef struct packed {
		logic [63:0] head;
		logic [31:0] tail;
		logic [3:0]  len;
		logic        ovf;
	} text_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      ang_valid;
	logic                      ang_stall;
	logic                      cmd;
	logic signed [ANGLE_W-1:0] angle;
	logic                      txt_valid;
	logic                      txt_stall;
	logic [63:0]               text_head;
	logic [31:0]               text_tail;
	logic [3:0]                text_length;
	logic                      field_overflow;

	text_word_t pending_text[$];
	int mismatch_count = 0;
	int words_checked = 0;
	int overflow_words = 0;
	int degree_words = 0;
	int input_stall_cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	angle_to_sexagesimal_ascii_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.ang_valid     (ang_valid),
		.ang_stall     (ang_stall),
		.cmd           (cmd),
		.angle         (angle),
		.txt_valid     (txt_valid),
		.txt_stall     (txt_stall),
		.text_head     (text_head),
		.text_tail     (text_tail),
		.text_length   (text_length),
		.field_overflow(field_overflow)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ASCII digit of the ones place of a value.
	function automatic logic [7:0] dec_char(input int v);
		return A_ZERO + 8'(v % 10);
	endfunction

	// Expected text word for one angle in the given mode.
	function automatic text_word_t format_angle(input logic mode, input logic [ANGLE_W-1:0] ang);
		logic [7:0] ch [12];
		logic [ANGLE_W-1:0] mag;
		logic [127:0] prod;
		logic [63:0] units;
		logic [63:0] min_part;
		logic [63:0] sec_part;
		logic is_neg;
		int whole;
		int mins;
		int secs;
		int tenths;
		int p;
		text_word_t w;
		for (int i = 0; i < 12; i++)
			ch[i] = 8'h00;
		w.ovf = 1'b0;
		is_neg = ang[ANGLE_W-1];
		// The most negative angle negates onto itself, which reads as 2^47 unsigned.
		mag = is_neg ? -ang : ang;
		prod = 128'(mag) * 128'(mode == CMD_DEG ? DEG_PER_RAD : HRS_PER_RAD);
		units = 64'(prod >> FRAC_BITS) + ROUND_UNIT;
		whole = int'(units >> 32);
		min_part = 64'(units[31:0]) * 64'd60;
		mins = int'(min_part >> 32);
		sec_part = 64'(min_part[31:0]) * 64'd60;
		secs = int'(sec_part >> 32);
		tenths = int'((64'(sec_part[31:0]) * 64'd10) >> 32);

		if (mode == CMD_HOURS) begin
			w.len = 4'd10;
			// Negative hours of one or more, or more than 99 hours, cannot be shown.
			if ((is_neg && whole != 0) || whole > 99) begin
				ch[0] = A_STAR;
				ch[1] = A_STAR;
				w.ovf = 1'b1;
			end else begin
				ch[0] = dec_char(whole / 10);
				ch[1] = dec_char(whole);
			end
			ch[2] = A_COLON;
			ch[3] = dec_char(mins / 10);
			ch[4] = dec_char(mins);
			ch[5] = A_COLON;
			p = 6;
		end else begin
			w.len = 4'd12;
			// The sign follows the angle itself, so small negative angles keep it.
			if (whole > 999) begin
				ch[0] = A_STAR;
				ch[1] = A_STAR;
				ch[2] = A_STAR;
				ch[3] = A_STAR;
				w.ovf = 1'b1;
			end else begin
				ch[0] = is_neg ? A_MINUS : A_PLUS;
				ch[1] = dec_char(whole / 100);
				ch[2] = dec_char((whole % 100) / 10);
				ch[3] = dec_char(whole);
			end
			ch[4] = A_COLON;
			ch[5] = dec_char(mins / 10);
			ch[6] = dec_char(mins);
			ch[7] = A_COLON;
			p = 8;
		end
		ch[p] = dec_char(secs / 10);
		ch[p + 1] = dec_char(secs);
		ch[p + 2] = A_DOT;
		ch[p + 3] = dec_char(tenths);

		w.head = {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], ch[6], ch[7]};
		w.tail = {ch[8], ch[9], ch[10], ch[11]};
		return w;
	endfunction

	// Random angle: full-range noise, ordinary angles, tiny angles, or one aimed at a
	// tenth-of-second step so that every carry between fields gets exercised.
	function automatic logic [ANGLE_W-1:0] pick_angle(input logic mode);
		logic [63:0] raw;
		logic [127:0] num;
		logic [ANGLE_W-1:0] mag;
		int unsigned kind;
		int unsigned top_unit;
		int unsigned t;
		raw = {$urandom, $urandom};
		kind = $urandom_range(99);
		if (kind < 20)
			return raw[ANGLE_W-1:0];
		if (kind < 55) begin
			mag = ANGLE_W'(raw % TWO_PI_UNITS);
		end else if (kind < 70) begin
			mag = ANGLE_W'(raw[31:0] >> $urandom_range(31));
		end else begin
			top_unit = (mode == CMD_DEG) ? 1000 : 100;
			if ($urandom_range(3) == 0)
				t = top_unit * TENTHS_PER_UNIT - 2 + $urandom_range(3);
			else
				t = $urandom_range((top_unit + 1) * TENTHS_PER_UNIT, 1);
			num = ((128'(t) << 32) / 128'(TENTHS_PER_UNIT)) - 128'(ROUND_UNIT);
			mag = ANGLE_W'(((num << FRAC_BITS) /
				128'(mode == CMD_DEG ? DEG_PER_RAD : HRS_PER_RAD)) +
				128'($urandom_range(127)) - 128'd64);
		end
		return raw[63] ? -mag : mag;
	endfunction

	// Offer one word after a random gap and record its expected text once accepted.
	task automatic send_word(input logic mode, input logic [ANGLE_W-1:0] ang);
		int gap;
		text_word_t want;
		gap = 0;
		while ($urandom_range(99) < gap_pct)
			gap++;
		if (gap > 0) begin
			ang_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ang_valid <= 1'b1;
		cmd <= mode;
		angle <= ang;
		do
			@(posedge clk);
		while (ang_stall);
		want = format_angle(mode, ang);
		pending_text.push_back(want);
		if (want.ovf)
			overflow_words++;
		if (mode == CMD_DEG)
			degree_words++;
	endtask

	// Stop offering and wait until every expected word has come out.
	task automatic drain_text();
		ang_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		gap_pct = 26;
		stall_pct = 26;
		// Zero, the smallest steps and the extremes of the angle field.
		send_word(CMD_HOURS, 48'h0);
		send_word(CMD_DEG, 48'h0);
		send_word(CMD_HOURS, 48'h1);
		send_word(CMD_DEG, 48'hFFFF_FFFF_FFFF);
		send_word(CMD_HOURS, 48'h7FFF_FFFF_FFFF);
		send_word(CMD_DEG, 48'h7FFF_FFFF_FFFF);
		send_word(CMD_HOURS, 48'h8000_0000_0000);
		send_word(CMD_DEG, 48'h8000_0000_0000);
		send_word(CMD_HOURS, 48'hAAAA_AAAA_AAAA);
		send_word(CMD_DEG, 48'h5555_5555_5555);
		// Negative angle under one hour reads as zero hours with no sign.
		send_word(CMD_HOURS, -48'd109951162778);
		send_word(CMD_DEG, -48'd109951162778);
		// A fraction of a negative degree keeps its minus sign.
		send_word(CMD_DEG, -48'd5497558139);
		// Negative hours of one or more turn into asterisks.
		send_word(CMD_HOURS, -48'd1099511627776);
		// Just over and just under the hour limit.
		send_word(CMD_HOURS, 48'd32985348833280);
		send_word(CMD_HOURS, 48'd28587302322176);
		// Just over and just under the degree limit, both signs.
		send_word(CMD_DEG, 48'd21990232555520);
		send_word(CMD_DEG, 48'd19131502323302);
		send_word(CMD_DEG, -48'd19131502323302);
		send_word(CMD_DEG, 48'd3454217652358);
		send_word(CMD_HOURS, 48'd6908435316000);
		send_word(CMD_HOURS, 48'hFFFF_FFFF_FFFF);
		drain_text();
	endtask

	task automatic test_random_traffic();
		int gaps [4] = '{0, 85, 0, 26};
		int stalls [4] = '{0, 0, 85, 26};
		logic mode;
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = gaps[ph];
			stall_pct = stalls[ph];
			repeat (100) begin
				mode = 1'($urandom_range(1));
				send_word(mode, pick_angle(mode));
			end
			drain_text();
		end
	endtask

	// Hold the output off while words keep coming, so the pipeline fills and
	// pushes back on its input.
	task automatic test_backpressure_fill();
		logic mode;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 60;
		repeat (40) begin
			mode = 1'($urandom_range(1));
			send_word(mode, pick_angle(mode));
		end
		drain_text();
	endtask

	// Output stall: a requested hold-off first, otherwise random at the phase rate.
	always @(posedge clk) begin : drive_stall
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			txt_stall <= 1'b1;
		end else begin
			txt_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each accepted output word with the oldest expected one.
	always @(posedge clk) begin : check_text
		text_word_t want;
		if (arst_n) begin
			if (ang_valid && ang_stall)
				input_stall_cycles++;
			if (txt_valid && !txt_stall) begin
				if (pending_text.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected word: head %h tail %h len %0d ovf %b",
							text_head, text_tail, text_length, field_overflow);
				end else begin
					want = pending_text.pop_front();
					words_checked++;
					if (text_head !== want.head || text_tail !== want.tail ||
						text_length !== want.len || field_overflow !== want.ovf) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch: expected head %h tail %h len %0d ovf %b, ",
								"got head %h tail %h len %0d ovf %b"},
								want.head, want.tail, want.len, want.ovf,
								text_head, text_tail, text_length, field_overflow);
					end
				end
			end
		end
	end

	initial begin : run_tests
		arst_n = 1'b0;
		ang_valid = 1'b0;
		cmd = CMD_HOURS;
		angle = '0;
		txt_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic();
		test_backpressure_fill();
		// Let anything stray fall out of the six-stage pipeline.
		repeat (20) @(posedge clk);
		$display("Checked %0d words, %0d in degree mode, %0d with an asterisk field.",
			words_checked, degree_words, overflow_words);
		$display("Input was held back for %0d cycles; %0d mismatches.",
			input_stall_cycles, mismatch_count);
		if (mismatch_count == 0 && pending_text.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
